FILE: src/dchl_pkg.sv
package dchl_pkg;

    localparam int DATA_W   = 8;
    localparam int VERDICT_W = 2;
    localparam int OFFSET_W = 17;
    localparam int LENGTH_W = 16;

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_FOUND      = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_INCOMPLETE = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_NO_SNI     = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_INVALID    = 2'd3;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [OFFSET_W-1:0]  ext_offset;
        logic [LENGTH_W-1:0]  ext_length;
    } t_result;

endpackage

FILE: src/dchl_in_if.sv
interface dchl_in_if import dchl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

FILE: src/dchl_out_if.sv
interface dchl_out_if import dchl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [OFFSET_W-1:0]  ext_offset;
    logic [LENGTH_W-1:0]  ext_length;

    modport source (output valid, verdict, ext_offset, ext_length, input ready);
    modport sink   (input valid, verdict, ext_offset, ext_length, output ready);
endinterface

FILE: src/dtls_client_hello_extension_locator_top.sv
// the verdict is loaded into the output register when the last byte leaves the input register
// throughput: one datagram byte per cycle, set by the per-byte parser step
// a stalled output only blocks when a second final byte would need the result register
// reset: i_rst_n is synchronous and active low; it clears the parser state and both valids
// after every verdict the parser state returns to its reset value for the next datagram
module dtls_client_hello_extension_locator_top import dchl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    dchl_in_if.sink    i_in,
    dchl_out_if.source o_out
);

    // input register: one byte per request
    logic              r_s1_valid;
    logic [DATA_W-1:0] r_s1_data;
    logic              r_s1_last;

    // result register
    logic              r_o_valid;
    t_result           r_o_res;

    logic              w_out_free;
    logic              w_step;
    t_result           w_res;

    // result slot is free when empty or being drained this cycle
    assign w_out_free = !r_o_valid || o_out.ready;

    // a non-final byte never needs the result slot, so it always moves on
    assign w_step = r_s1_valid && (!r_s1_last || w_out_free);

    // take a new byte whenever the input register empties this cycle
    assign i_in.ready = !r_s1_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_data <= i_in.data_byte;
            r_s1_last <= i_in.last_byte;
        end
    end

    // per-byte parser: header checks, field skipping and verdict
    dchl_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_data  (r_s1_data),
        .i_last  (r_s1_last),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_step && r_s1_last) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_s1_last) begin
            r_o_res <= w_res;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.verdict    = r_o_res.verdict;
    assign o_out.ext_offset = r_o_res.ext_offset;
    assign o_out.ext_length = r_o_res.ext_length;

    a_final_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && r_s1_last |=> r_o_valid)
        else $error("final byte consumed without a verdict");

    a_final_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_last && !w_out_free |=> r_s1_valid && r_s1_last)
        else $error("final byte lost while the result slot was busy");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_res.verdict != VERDICT_FOUND
            |-> r_o_res.ext_offset == '0 && r_o_res.ext_length == '0)
        else $error("extension fields set without a found verdict");

endmodule

FILE: src/dchl_parse.sv
module dchl_parse import dchl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_last,
    output t_result           o_res
);

    localparam logic [3:0] PH_HDR        = 4'd0;
    localparam logic [3:0] PH_RAND       = 4'd1;
    localparam logic [3:0] PH_SID_LEN    = 4'd2;
    localparam logic [3:0] PH_SID        = 4'd3;
    localparam logic [3:0] PH_COOKIE_LEN = 4'd4;
    localparam logic [3:0] PH_COOKIE     = 4'd5;
    localparam logic [3:0] PH_CS_HI      = 4'd6;
    localparam logic [3:0] PH_CS_LO      = 4'd7;
    localparam logic [3:0] PH_CS         = 4'd8;
    localparam logic [3:0] PH_CM_LEN     = 4'd9;
    localparam logic [3:0] PH_CM         = 4'd10;
    localparam logic [3:0] PH_EXT_HI     = 4'd11;
    localparam logic [3:0] PH_EXT_LO     = 4'd12;
    localparam logic [3:0] PH_DONE       = 4'd13;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_FOUND   = 3'd1;
    localparam logic [2:0] ERR_NOSNI   = 3'd2;
    localparam logic [2:0] ERR_INVALID = 3'd3;
    localparam logic [2:0] ERR_HEADER  = 3'd4;

    localparam logic [7:0]  CT_HANDSHAKE = 8'h16;
    localparam logic [7:0]  VER_MAJOR    = 8'hFE;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [16:0] POS_MAX      = 17'h1FFFF;
    localparam logic [15:0] RAND_LEN     = 16'd34;

    typedef struct packed {
        logic [3:0]  phase;
        logic [2:0]  err;
        logic [15:0] rem;
    } t_ctl;

    logic [16:0] r_pos, n_pos;
    logic [15:0] r_rec_len, n_rec_len;
    logic [23:0] r_hs_len, n_hs_len;
    logic [23:0] r_frag_len, n_frag_len;
    logic        r_frag_off_nz, n_frag_off_nz;
    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_rem, n_rem;
    logic [2:0]  r_err, n_err;
    logic [16:0] r_found_off, n_found_off;
    logic [15:0] r_found_len, n_found_len;

    logic [24:0] w_p;
    logic [24:0] w_e;
    logic [23:0] w_frag_new;
    logic [15:0] w_len16;
    t_ctl        w_ctl;

    function automatic t_ctl conclude(input logic [2:0] code, input logic [15:0] rem);
        t_ctl res;
        res = '{phase: PH_DONE, err: code, rem: rem};
        return res;
    endfunction

    // bounds check on entry to a phase whose first byte sits at p
    function automatic t_ctl enter_phase(input logic [3:0] ph, input logic [24:0] p,
                                         input logic [24:0] e, input logic [15:0] rem);
        t_ctl res;
        res = '{phase: ph, err: ERR_NONE, rem: rem};
        if (ph == PH_SID_LEN || ph == PH_COOKIE_LEN || ph == PH_CM_LEN) begin
            if (p >= e) res = conclude(ERR_INVALID, rem);
        end else if (ph == PH_CS_HI) begin
            if (e < p + 25'd2) res = conclude(ERR_INVALID, rem);
        end else if (ph == PH_EXT_HI) begin
            if (p == e) res = conclude(ERR_NOSNI, rem);
            else if (e < p + 25'd2) res = conclude(ERR_INVALID, rem);
        end
        return res;
    endfunction

    function automatic t_ctl take_length(input logic [15:0] len, input logic [24:0] p,
                                         input logic [24:0] e, input logic [3:0] skip_ph,
                                         input logic [3:0] next_ph, input logic [15:0] rem);
        t_ctl res;
        if ((p <= e) && ((e - p) < {9'd0, len})) res = conclude(ERR_INVALID, rem);
        else if (len == 16'd0) res = enter_phase(next_ph, p, e, rem);
        else res = '{phase: skip_ph, err: ERR_NONE, rem: len};
        return res;
    endfunction

    function automatic t_ctl skip_byte(input logic [24:0] p, input logic [24:0] e,
                                       input logic [3:0] cur_ph, input logic [3:0] next_ph,
                                       input logic [15:0] rem);
        t_ctl        res;
        logic [15:0] dec;
        dec = rem - 16'd1;
        if (dec == 16'd0) res = enter_phase(next_ph, p, e, dec);
        else res = '{phase: cur_ph, err: ERR_NONE, rem: dec};
        return res;
    endfunction

    assign w_p        = {8'd0, r_pos} + 25'd1;
    assign w_e        = 25'd25 + {1'b0, r_frag_len};
    assign w_frag_new = {r_frag_len[15:0], i_data};
    assign w_len16    = {r_rem[15:8], i_data};

    always_comb begin
        w_ctl         = '{phase: r_phase, err: r_err, rem: r_rem};
        n_rec_len     = r_rec_len;
        n_hs_len      = r_hs_len;
        n_frag_len    = r_frag_len;
        n_frag_off_nz = r_frag_off_nz;
        n_found_off   = r_found_off;
        n_found_len   = r_found_len;

        if (r_err == ERR_NONE) begin
            if (r_phase == PH_HDR) begin
                case (r_pos)
                    17'd0: if (i_data != CT_HANDSHAKE) w_ctl = conclude(ERR_HEADER, r_rem);
                    17'd1: if (i_data != VER_MAJOR) w_ctl = conclude(ERR_HEADER, r_rem);
                    17'd3, 17'd4: if (i_data != 8'd0) w_ctl = conclude(ERR_HEADER, r_rem);
                    17'd11: n_rec_len = {i_data, 8'd0};
                    17'd12: begin
                        n_rec_len = {r_rec_len[15:8], i_data};
                        if ({r_rec_len[15:8], i_data} < 16'd12)
                            w_ctl = conclude(ERR_INVALID, r_rem);
                    end
                    17'd13: if (i_data != HS_CLIENT_HELLO) w_ctl = conclude(ERR_INVALID, r_rem);
                    17'd14, 17'd15, 17'd16: n_hs_len = {r_hs_len[15:0], i_data};
                    17'd19, 17'd20, 17'd21: if (i_data != 8'd0) n_frag_off_nz = 1'b1;
                    17'd22, 17'd23: n_frag_len = w_frag_new;
                    17'd24: begin
                        n_frag_len = w_frag_new;
                        if (r_frag_off_nz) w_ctl = conclude(ERR_NOSNI, r_rem);
                        else if (w_frag_new != r_hs_len) w_ctl = conclude(ERR_NOSNI, r_rem);
                        else if ({1'b0, w_frag_new} + 25'd12 > {9'd0, r_rec_len})
                            w_ctl = conclude(ERR_INVALID, r_rem);
                        else if (w_frag_new < 24'd34) w_ctl = conclude(ERR_INVALID, r_rem);
                        else w_ctl = '{phase: PH_RAND, err: ERR_NONE, rem: RAND_LEN};
                    end
                    default: ;
                endcase
            end else begin
                unique case (r_phase)
                    PH_RAND:       w_ctl = skip_byte(w_p, w_e, PH_RAND, PH_SID_LEN, r_rem);
                    PH_SID_LEN:    w_ctl = take_length({8'd0, i_data}, w_p, w_e, PH_SID,
                                                       PH_COOKIE_LEN, r_rem);
                    PH_SID:        w_ctl = skip_byte(w_p, w_e, PH_SID, PH_COOKIE_LEN, r_rem);
                    PH_COOKIE_LEN: w_ctl = take_length({8'd0, i_data}, w_p, w_e, PH_COOKIE,
                                                       PH_CS_HI, r_rem);
                    PH_COOKIE:     w_ctl = skip_byte(w_p, w_e, PH_COOKIE, PH_CS_HI, r_rem);
                    PH_CS_HI:      w_ctl = '{phase: PH_CS_LO, err: ERR_NONE,
                                             rem: {i_data, 8'd0}};
                    PH_CS_LO:      w_ctl = take_length(w_len16, w_p, w_e, PH_CS,
                                                       PH_CM_LEN, r_rem);
                    PH_CS:         w_ctl = skip_byte(w_p, w_e, PH_CS, PH_CM_LEN, r_rem);
                    PH_CM_LEN:     w_ctl = take_length({8'd0, i_data}, w_p, w_e, PH_CM,
                                                       PH_EXT_HI, r_rem);
                    PH_CM:         w_ctl = skip_byte(w_p, w_e, PH_CM, PH_EXT_HI, r_rem);
                    PH_EXT_HI:     w_ctl = '{phase: PH_EXT_LO, err: ERR_NONE,
                                             rem: {i_data, 8'd0}};
                    PH_EXT_LO: begin
                        if ((w_p <= w_e) && ((w_e - w_p) < {9'd0, w_len16})) begin
                            w_ctl = conclude(ERR_INVALID, r_rem);
                        end else begin
                            n_found_off = w_p[16:0];
                            n_found_len = w_len16;
                            w_ctl       = conclude(ERR_FOUND, r_rem);
                        end
                    end
                    default: ;
                endcase
            end
        end

        n_phase = w_ctl.phase;
        n_err   = w_ctl.err;
        n_rem   = w_ctl.rem;
        n_pos   = (r_pos == POS_MAX) ? r_pos : r_pos + 17'd1;

        // verdict from the state after this byte, check order kept
        o_res = '{verdict: VERDICT_INCOMPLETE, ext_offset: '0, ext_length: '0};
        if (w_p < 25'd13)                            o_res.verdict = VERDICT_INCOMPLETE;
        else if (n_err == ERR_HEADER)                o_res.verdict = VERDICT_INVALID;
        else if (w_p < 25'd13 + {9'd0, n_rec_len})   o_res.verdict = VERDICT_INCOMPLETE;
        else if (n_err == ERR_FOUND) begin
            o_res.verdict    = VERDICT_FOUND;
            o_res.ext_offset = n_found_off;
            o_res.ext_length = n_found_len;
        end
        else if (n_err == ERR_NOSNI)                 o_res.verdict = VERDICT_NO_SNI;
        else if (n_err == ERR_INVALID)               o_res.verdict = VERDICT_INVALID;
        else                                         o_res.verdict = VERDICT_INCOMPLETE;

        // datagram end: back to the start state
        if (i_last) begin
            n_pos         = '0;
            n_rec_len     = '0;
            n_hs_len      = '0;
            n_frag_len    = '0;
            n_frag_off_nz = 1'b0;
            n_phase       = PH_HDR;
            n_rem         = '0;
            n_err         = ERR_NONE;
            n_found_off   = '0;
            n_found_len   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_rec_len     <= '0;
            r_hs_len      <= '0;
            r_frag_len    <= '0;
            r_frag_off_nz <= 1'b0;
            r_phase       <= PH_HDR;
            r_rem         <= '0;
            r_err         <= ERR_NONE;
            r_found_off   <= '0;
            r_found_len   <= '0;
        end else if (i_step) begin
            r_pos         <= n_pos;
            r_rec_len     <= n_rec_len;
            r_hs_len      <= n_hs_len;
            r_frag_len    <= n_frag_len;
            r_frag_off_nz <= n_frag_off_nz;
            r_phase       <= n_phase;
            r_rem         <= n_rem;
            r_err         <= n_err;
            r_found_off   <= n_found_off;
            r_found_len   <= n_found_len;
        end
    end

    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err == ERR_FOUND |-> r_phase == PH_DONE)
        else $error("found without finishing the parse");

    a_body_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HDR && r_phase != PH_DONE) |-> r_pos >= 17'd25)
        else $error("body phase before the handshake header ended");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> r_pos == '0 && r_phase == PH_HDR && r_err == ERR_NONE)
        else $error("state not cleared after datagram end");

endmodule
